// File: hw/rtl/voxel_grid_coefficient_lookup_assert.svh
// Assertion helpers for the voxel grid lookup.
// Both expect clk and rst_n to be visible where they are used.
`ifndef VOXEL_GRID_COEFFICIENT_LOOKUP_ASSERT_SVH
`define VOXEL_GRID_COEFFICIENT_LOOKUP_ASSERT_SVH

// Same-cycle implication
`define VGCL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define VGCL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/vgcl_pkg.sv
package vgcl_pkg;

    // Request kinds
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Orientation codes
    localparam logic [1:0] ORIENT_FULL = 2'd0;
    localparam logic [1:0] ORIENT_XY   = 2'd1;
    localparam logic [1:0] ORIENT_XZ   = 2'd2;
    localparam logic [1:0] ORIENT_YZ   = 2'd3;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_X      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Y      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_Z      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ORIENTATION = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SLICE_INDEX = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_X     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Y     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Z     = 3'd7;

    // Field widths
    localparam int COORD_W = 32;
    localparam int SCALE_W = 24;
    localparam int SIZE_W  = 6;
    localparam int SLICE_W = 5;
    localparam int WORD_W  = 32;

    typedef struct packed {
        logic                      req_type;
        logic [WORD_W-1:0]         load_value;
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
    } req_t;

    typedef struct packed {
        logic [WORD_W-1:0] perm_0;
        logic [WORD_W-1:0] perm_1;
        logic [WORD_W-1:0] perm_2;
        logic [1:0]        component_count;
    } rsp_t;

endpackage

// File: hw/rtl/voxel_grid_coefficient_lookup.sv
// Nearest-cell coefficient lookup over a 3-D grid, clamped to the grid edge.
// Request channel (req_valid/req_ready, payload req): a load transaction writes
// the next coefficient word (x fastest, then y, z, component); a query
// transaction carries 2 or 3 signed Q16.16 coordinates.
// Response channel (rsp_valid/rsp_ready, payload rsp): one transaction per
// query with 3 components in full 3-D mode, 2 in a slice mode.
// Configuration: cfg_we/cfg_index/cfg_data, which must be written only while
// idle; the block itself does not enforce this. Loads do not leave idle, so
// loads stream back to back. A query is taken only while idle: the accept
// cycle registers the multiply, then come a clamp and address step, one read
// of the single memory port per component, and the handoff to the response
// register; req_ready is low from the clamp step through the handoff, which
// registers the response and raises rsp_valid.
// A held response does not block loads or the start of the next query; a
// finished query waits in its last step until the response register frees.
// Reset: sizes 32, scales 1.0, 3-D mode, slice 0, load position at the start.
// Store contents are undefined after reset and are not cleared.
module voxel_grid_coefficient_lookup #(
    parameter int MAX_DIM     = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_ready,
    input  vgcl_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output vgcl_pkg::rsp_t                      rsp,
    input  logic                                cfg_we,
    input  logic [vgcl_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [vgcl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int DEPTH = 3 * CELLS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CLAMP = 2'd1;
    localparam logic [1:0] ST_READ  = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    // Last valid cell index from a size register
    function automatic logic [IW-1:0] last_index(input logic [vgcl_pkg::SIZE_W-1:0] s);
        logic [IW-1:0] r;
        if (s == '0)
        begin
            r = '0;
        end
        else if (32'(s) > 32'(MAX_DIM))
        begin
            r = IW'(MAX_DIM - 1);
        end
        else
        begin
            r = IW'(s - 1'b1);
        end
        return r;
    endfunction

    // Slice index saturated to the last cell of its axis
    function automatic logic [IW-1:0] sat_slice(input logic [vgcl_pkg::SLICE_W-1:0] s,
                                                input logic [IW-1:0] lim);
        logic [IW-1:0] r;
        if (32'(s) > 32'(lim))
        begin
            r = lim;
        end
        else
        begin
            r = IW'(s);
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] cell_of(input logic [IW-1:0] x,
                                              input logic [IW-1:0] y,
                                              input logic [IW-1:0] z);
        return AW'(x) + AW'(MAX_DIM) * (AW'(y) + AW'(MAX_DIM) * AW'(z));
    endfunction

    function automatic logic [AW-1:0] comp_base(input logic [1:0] c);
        return AW'(c) * AW'(CELLS);
    endfunction

    // Component returned at read step k for a given orientation
    function automatic logic [1:0] comp_sel(input logic [1:0] mode, input logic [1:0] k);
        logic [1:0] c;
        case (mode)
            vgcl_pkg::ORIENT_XZ: c = (k == 2'd0) ? 2'd0 : 2'd2;
            vgcl_pkg::ORIENT_YZ: c = (k == 2'd0) ? 2'd1 : 2'd2;
            default:             c = k;
        endcase
        return c;
    endfunction

    // Configuration registers
    logic [vgcl_pkg::SIZE_W-1:0]  size_x_reg, size_y_reg, size_z_reg;
    logic [1:0]                   orientation_reg;
    logic [vgcl_pkg::SLICE_W-1:0] slice_index_reg;
    logic [vgcl_pkg::SCALE_W-1:0] scale_x_reg, scale_y_reg, scale_z_reg;

    // Control state
    logic [1:0]    state_reg, state_next;
    logic [1:0]    mode_reg, mode_next;
    logic [1:0]    rd_cnt_reg, rd_cnt_next;
    logic [IW-1:0] load_x_reg, load_x_next;
    logic [IW-1:0] load_y_reg, load_y_next;
    logic [IW-1:0] load_z_reg, load_z_next;
    logic [1:0]    load_comp_reg, load_comp_next;
    logic          rsp_valid_reg, rsp_valid_next;

    // Datapath registers
    logic [AW-1:0]                 cell_reg, cell_next;
    logic [vgcl_pkg::WORD_W-1:0]   lane0_reg, lane0_next;
    logic [vgcl_pkg::WORD_W-1:0]   lane1_reg, lane1_next;
    vgcl_pkg::rsp_t                rsp_reg, rsp_next;
    logic [VALUE_WIDTH-1:0]        rd_data_reg;

    logic [VALUE_WIDTH-1:0] coef_mem [DEPTH];

    logic                          req_fire;
    logic                          is_load, is_query;
    logic                          fin_go;
    logic [IW-1:0]                 lim_x, lim_y, lim_z;
    logic [IW-1:0]                 idx_x, idx_y, idx_z;
    logic [IW-1:0]                 cel_x, cel_y, cel_z;
    logic [1:0]                    rd_last;
    logic                          rd_en;
    logic [AW-1:0]                 rd_addr;
    logic                          mem_we;
    logic [AW-1:0]                 wr_addr;
    logic [VALUE_WIDTH-1:0]        wr_data;
    logic signed [vgcl_pkg::COORD_W-1:0] mul_y_coord, mul_z_coord;
    logic [vgcl_pkg::WORD_W-1:0]   rd_word;

    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;
    assign is_load   = req_fire && (req.req_type == vgcl_pkg::REQ_LOAD);
    assign is_query  = req_fire && (req.req_type == vgcl_pkg::REQ_QUERY);

    assign lim_x = last_index(size_x_reg);
    assign lim_y = last_index(size_y_reg);
    assign lim_z = last_index(size_z_reg);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg      <= 6'd32;
            size_y_reg      <= 6'd32;
            size_z_reg      <= 6'd32;
            orientation_reg <= vgcl_pkg::ORIENT_FULL;
            slice_index_reg <= '0;
            scale_x_reg     <= 24'd65536;
            scale_y_reg     <= 24'd65536;
            scale_z_reg     <= 24'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                vgcl_pkg::REG_SIZE_X:      size_x_reg      <= cfg_data[vgcl_pkg::SIZE_W-1:0];
                vgcl_pkg::REG_SIZE_Y:      size_y_reg      <= cfg_data[vgcl_pkg::SIZE_W-1:0];
                vgcl_pkg::REG_SIZE_Z:      size_z_reg      <= cfg_data[vgcl_pkg::SIZE_W-1:0];
                vgcl_pkg::REG_ORIENTATION: orientation_reg <= cfg_data[1:0];
                vgcl_pkg::REG_SLICE_INDEX: slice_index_reg <= cfg_data[vgcl_pkg::SLICE_W-1:0];
                vgcl_pkg::REG_SCALE_X:     scale_x_reg     <= cfg_data;
                vgcl_pkg::REG_SCALE_Y:     scale_y_reg     <= cfg_data;
                vgcl_pkg::REG_SCALE_Z:     scale_z_reg     <= cfg_data;
                default:                   ;
            endcase
        end
    end

    // Coordinate routing per orientation; x always takes the first coordinate
    assign mul_y_coord = (orientation_reg == vgcl_pkg::ORIENT_YZ) ? req.coord_0 : req.coord_1;
    assign mul_z_coord = (orientation_reg == vgcl_pkg::ORIENT_FULL) ? req.coord_2 : req.coord_1;

    vgcl_cell_index #(.IDX_W(IW)) u_idx_x (
        .clk   (clk),
        .load  (is_query),
        .coord (req.coord_0),
        .scale (scale_x_reg),
        .lim   (lim_x),
        .idx   (idx_x)
    );

    vgcl_cell_index #(.IDX_W(IW)) u_idx_y (
        .clk   (clk),
        .load  (is_query),
        .coord (mul_y_coord),
        .scale (scale_y_reg),
        .lim   (lim_y),
        .idx   (idx_y)
    );

    vgcl_cell_index #(.IDX_W(IW)) u_idx_z (
        .clk   (clk),
        .load  (is_query),
        .coord (mul_z_coord),
        .scale (scale_z_reg),
        .lim   (lim_z),
        .idx   (idx_z)
    );

    // Fixed axis takes the saturated slice index
    assign cel_x = (mode_reg == vgcl_pkg::ORIENT_YZ) ? sat_slice(slice_index_reg, lim_x) : idx_x;
    assign cel_y = (mode_reg == vgcl_pkg::ORIENT_XZ) ? sat_slice(slice_index_reg, lim_y) : idx_y;
    assign cel_z = (mode_reg == vgcl_pkg::ORIENT_XY) ? sat_slice(slice_index_reg, lim_z) : idx_z;

    assign rd_last = (mode_reg == vgcl_pkg::ORIENT_FULL) ? 2'd2 : 2'd1;
    assign rd_en   = (state_reg == ST_READ);
    assign rd_addr = comp_base(comp_sel(mode_reg, rd_cnt_reg)) + cell_reg;
    assign rd_word = vgcl_pkg::WORD_W'(rd_data_reg);
    assign fin_go  = (state_reg == ST_FIN) && (!rsp_valid_reg || rsp_ready);

    // Load path: write at the current load position
    assign mem_we  = is_load;
    assign wr_addr = comp_base(load_comp_reg) + cell_of(load_x_reg, load_y_reg, load_z_reg);
    assign wr_data = VALUE_WIDTH'(req.load_value);

    // Load position counters, x fastest; wrap at the current sizes
    always_comb
    begin
        load_x_next    = load_x_reg;
        load_y_next    = load_y_reg;
        load_z_next    = load_z_reg;
        load_comp_next = load_comp_reg;
        if (is_load)
        begin
            if (load_x_reg >= lim_x)
            begin
                load_x_next = '0;
                if (load_y_reg >= lim_y)
                begin
                    load_y_next = '0;
                    if (load_z_reg >= lim_z)
                    begin
                        load_z_next    = '0;
                        load_comp_next = (load_comp_reg >= 2'd2) ? 2'd0 : 2'(load_comp_reg + 1'b1);
                    end
                    else
                    begin
                        load_z_next = IW'(load_z_reg + 1'b1);
                    end
                end
                else
                begin
                    load_y_next = IW'(load_y_reg + 1'b1);
                end
            end
            else
            begin
                load_x_next = IW'(load_x_reg + 1'b1);
            end
        end
    end

    // Query sequencer
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rd_cnt_next    = rd_cnt_reg;
        cell_next      = cell_reg;
        lane0_next     = lane0_reg;
        lane1_next     = lane1_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (is_query)
                begin
                    mode_next  = orientation_reg;
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP:
            begin
                cell_next   = cell_of(cel_x, cel_y, cel_z);
                rd_cnt_next = '0;
                state_next  = ST_READ;
            end
            ST_READ:
            begin
                // Read data is registered: each step captures the word read in the step before
                if (rd_cnt_reg == 2'd1)
                begin
                    lane0_next = rd_word;
                end
                if (rd_cnt_reg == 2'd2)
                begin
                    lane1_next = rd_word;
                end
                rd_cnt_next = 2'(rd_cnt_reg + 1'b1);
                if (rd_cnt_reg == rd_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // Last component comes straight from the memory read register
                if (fin_go)
                begin
                    rsp_next.perm_0 = lane0_reg;
                    if (mode_reg == vgcl_pkg::ORIENT_FULL)
                    begin
                        rsp_next.perm_1          = lane1_reg;
                        rsp_next.perm_2          = rd_word;
                        rsp_next.component_count = 2'd3;
                    end
                    else
                    begin
                        rsp_next.perm_1          = rd_word;
                        rsp_next.perm_2          = '0;
                        rsp_next.component_count = 2'd2;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= vgcl_pkg::ORIENT_FULL;
            rd_cnt_reg    <= '0;
            load_x_reg    <= '0;
            load_y_reg    <= '0;
            load_z_reg    <= '0;
            load_comp_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rd_cnt_reg    <= rd_cnt_next;
            load_x_reg    <= load_x_next;
            load_y_reg    <= load_y_next;
            load_z_reg    <= load_z_next;
            load_comp_reg <= load_comp_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cell_reg  <= cell_next;
        lane0_reg <= lane0_next;
        lane1_reg <= lane1_next;
        rsp_reg   <= rsp_next;
    end

    // Coefficient store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            coef_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= coef_mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `include "voxel_grid_coefficient_lookup_assert.svh"

    `VGCL_ASSERT_IMP(a_rd_cnt_range, state_reg == ST_READ, rd_cnt_reg <= rd_last,
        "read step beyond the component count")
    `VGCL_ASSERT_IMP(a_wr_when_idle, mem_we, (state_reg == ST_IDLE) && !rd_en,
        "store written while a query reads it")
    `VGCL_ASSERT_NXT(a_fin_delivers, fin_go, rsp_valid_reg && (state_reg == ST_IDLE),
        "finished query did not reach the response register")
    `VGCL_ASSERT_IMP(a_load_comp_range, 1'b1, load_comp_reg != 2'd3,
        "load component counter out of range")

endmodule

// File: hw/rtl/vgcl_cell_index.sv
// Scale one coordinate to a cell index: registered multiply, then floor and clamp.
module vgcl_cell_index #(
    parameter int IDX_W = 5
) (
    input  logic                                clk,
    input  logic                                load,
    input  logic signed [vgcl_pkg::COORD_W-1:0] coord,
    input  logic [vgcl_pkg::SCALE_W-1:0]        scale,
    input  logic [IDX_W-1:0]                    lim,
    output logic [IDX_W-1:0]                    idx
);

    localparam int PROD_W = vgcl_pkg::COORD_W + vgcl_pkg::SCALE_W + 1;
    localparam int Q_W    = PROD_W - 1 - 32;

    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [Q_W-1:0]           q;
    logic                     neg;

    // Signed coordinate times unsigned scale, Q25.32
    assign prod_next = coord * $signed({1'b0, scale});

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            prod_reg <= prod_next;
        end
    end

    // Floor is the integer part; negative goes to 0, beyond the grid to the last cell
    assign neg = prod_reg[PROD_W-1];
    assign q   = prod_reg[PROD_W-2:32];

    always_comb
    begin
        if (neg)
        begin
            idx = '0;
        end
        else if (q > Q_W'(lim))
        begin
            idx = lim;
        end
        else
        begin
            idx = IDX_W'(q);
        end
    end

endmodule
